>>> design/ipfc_pkg.sv
// ----------------------------------------------------------------------------
// ipfc_pkg
// types, offsets and codes shared by the ipv4 frame classifier
// ----------------------------------------------------------------------------
package ipfc_pkg;

    localparam int MAX_NICS    = 8;
    localparam int NIC_COUNT_W = 4;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_OSPF = 8'd89;
    localparam logic [3:0]  IHL_MASK   = 4'hF;
    localparam logic [3:0]  IHL_MIN    = 4'd5;

    localparam logic [15:0] SVC_SSH   = 16'd22;
    localparam logic [15:0] SVC_HTTPS = 16'd443;
    localparam logic [15:0] SVC_BGP   = 16'd179;
    localparam logic [15:0] SVC_DHCPS = 16'd67;
    localparam logic [15:0] SVC_DHCPC = 16'd68;
    localparam logic [15:0] SVC_DNS   = 16'd53;
    localparam logic [15:0] SVC_SNMP  = 16'd161;

    localparam logic [6:0] OFF_ETYPE_HI = 7'd12;
    localparam logic [6:0] OFF_ETYPE_LO = 7'd13;
    localparam logic [6:0] OFF_IP_START = 7'd14;
    localparam logic [6:0] OFF_PROTO    = 7'd23;
    localparam logic [6:0] OFF_DST_B3   = 7'd30;
    localparam logic [6:0] OFF_DST_B2   = 7'd31;
    localparam logic [6:0] OFF_DST_B1   = 7'd32;
    localparam logic [6:0] OFF_DST_B0   = 7'd33;
    localparam logic [6:0] OFFSET_MAX   = 7'd127;

    localparam logic [5:0] PREFIX_LEN_MAX = 6'd32;

    typedef enum logic [1:0] {
        VD_FORWARD = 2'd0,
        VD_PUNT    = 2'd1,
        VD_LOCAL   = 2'd2,
        VD_DROP    = 2'd3
    } t_verdict;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        frame_last;
        logic        from_fabric;
        logic [2:0]  rx_nic;
        logic [3:0]  entry_index;
        logic [31:0] entry_net;
        logic [5:0]  entry_len;
        logic        entry_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic       egress_fabric;
        logic [2:0] egress_nic;
    } t_out_item;

    typedef struct packed {
        logic [15:0] eth_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic        from_fabric;
        logic [2:0]  nic;
    } t_hdr;

    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [31:0] net;
        logic [5:0]  len;
        logic        valid;
    } t_prefix_wr;

    function automatic logic [31:0] prefix_reset_net(input int idx);
        logic [31:0] net;
        case (idx)
            0:       net = 32'h0A00_0000;
            1:       net = 32'hAC10_0000;
            2:       net = 32'hC0A8_0000;
            default: net = '0;
        endcase
        return net;
    endfunction

    function automatic logic [5:0] prefix_reset_len(input int idx);
        logic [5:0] len;
        case (idx)
            0:       len = 6'd8;
            1:       len = 6'd12;
            2:       len = 6'd16;
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

>>> design/ipfc_in_if.sv
// ----------------------------------------------------------------------------
// ipfc_in_if
// input channel: frame bytes and prefix table writes
// ----------------------------------------------------------------------------
interface ipfc_in_if;
    import ipfc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ipfc_out_if.sv
// ----------------------------------------------------------------------------
// ipfc_out_if
// result channel: one verdict word per frame
// ----------------------------------------------------------------------------
interface ipfc_out_if;
    import ipfc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ipfc_cfg_if.sv
// ----------------------------------------------------------------------------
// ipfc_cfg_if
// configuration write channel: nic count
// ----------------------------------------------------------------------------
interface ipfc_cfg_if;
    import ipfc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [NIC_COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ipfc_hdr_capture.sv
// ----------------------------------------------------------------------------
// ipfc_hdr_capture
// byte offset tracking and header field capture, current view includes
// the byte being processed
// ----------------------------------------------------------------------------
module ipfc_hdr_capture (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_en,
    input  logic [7:0]    i_data_byte,
    input  logic          i_frame_last,
    input  logic          i_from_fabric,
    input  logic [2:0]    i_rx_nic,
    output ipfc_pkg::t_hdr o_hdr
);
    import ipfc_pkg::*;

    logic [6:0] r_offset;
    logic [6:0] n_offset;
    t_hdr       r_hdr;
    t_hdr       base;
    t_hdr       cur;
    logic [7:0] l4_start;

    always_comb begin
        base = r_hdr;
        if (r_offset == '0) begin
            base             = '0;
            base.from_fabric = i_from_fabric;
            base.nic         = i_rx_nic;
        end
        cur = base;
        if (r_offset == OFF_ETYPE_HI) cur.eth_type[15:8] = i_data_byte;
        if (r_offset == OFF_ETYPE_LO) cur.eth_type[7:0] = i_data_byte;
        if (r_offset == OFF_IP_START) cur.header_words = i_data_byte[3:0] & IHL_MASK;
        if (r_offset == OFF_PROTO) cur.ip_protocol = i_data_byte;
        if (r_offset == OFF_DST_B3) cur.dest_address[31:24] = i_data_byte;
        if (r_offset == OFF_DST_B2) cur.dest_address[23:16] = i_data_byte;
        if (r_offset == OFF_DST_B1) cur.dest_address[15:8] = i_data_byte;
        if (r_offset == OFF_DST_B0) cur.dest_address[7:0] = i_data_byte;
        l4_start = {1'b0, OFF_IP_START} + {2'b00, cur.header_words, 2'b00};
        if (cur.header_words >= IHL_MIN && r_offset >= OFF_IP_START) begin
            if ({1'b0, r_offset} == l4_start + 8'd2) cur.dest_port[15:8] = i_data_byte;
            if ({1'b0, r_offset} == l4_start + 8'd3) cur.dest_port[7:0] = i_data_byte;
        end
    end

    always_comb begin
        if (i_frame_last) begin
            n_offset = '0;
        end else if (r_offset != OFFSET_MAX) begin
            n_offset = r_offset + 7'd1;
        end else begin
            n_offset = r_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_hdr    <= '0;
        end else if (i_byte_en) begin
            r_offset <= n_offset;
            r_hdr    <= cur;
        end
    end

    assign o_hdr = cur;

endmodule

>>> design/ipfc_prefix_match.sv
// ----------------------------------------------------------------------------
// ipfc_prefix_match
// prefix table in flops with a parallel masked compare of all slots
// ----------------------------------------------------------------------------
module ipfc_prefix_match #(
    parameter int PREFIX_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipfc_pkg::t_prefix_wr i_wr,
    input  logic [31:0]         i_addr,
    output logic                o_hit
);
    import ipfc_pkg::*;

    logic [31:0]               r_net   [PREFIX_ENTRIES];
    logic [5:0]                r_len   [PREFIX_ENTRIES];
    logic [PREFIX_ENTRIES-1:0] r_valid;
    logic [PREFIX_ENTRIES-1:0] hit_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PREFIX_ENTRIES; i++) begin
                r_net[i]   <= prefix_reset_net(i);
                r_len[i]   <= prefix_reset_len(i);
                r_valid[i] <= (i < 3);
            end
        end else if (i_wr.en) begin
            for (int i = 0; i < PREFIX_ENTRIES; i++) begin
                if (int'(i_wr.index) == i) begin
                    r_net[i]   <= i_wr.net;
                    r_len[i]   <= i_wr.len;
                    r_valid[i] <= i_wr.valid;
                end
            end
        end
    end

    always_comb begin
        logic [5:0]  len_c;
        logic [31:0] mask;
        for (int i = 0; i < PREFIX_ENTRIES; i++) begin
            len_c      = (r_len[i] > PREFIX_LEN_MAX) ? PREFIX_LEN_MAX : r_len[i];
            mask       = ~(32'hFFFF_FFFF >> len_c);
            hit_vec[i] = r_valid[i] && ((i_addr & mask) == r_net[i]);
        end
    end

    assign o_hit = |hit_vec;

endmodule

>>> design/ipfc_verdict.sv
// ----------------------------------------------------------------------------
// ipfc_verdict
// frame classification and egress selection from captured header fields
// ----------------------------------------------------------------------------
module ipfc_verdict (
    input  ipfc_pkg::t_hdr              i_hdr,
    input  logic                        i_hit,
    input  logic [ipfc_pkg::NIC_COUNT_W-1:0] i_nic_count,
    output ipfc_pkg::t_out_item         o_item
);
    import ipfc_pkg::*;

    logic [15:0]            port;
    logic                   mgmt;
    t_verdict               cls;
    logic [NIC_COUNT_W-1:0] nics;
    logic [NIC_COUNT_W-1:0] next_nic;

    always_comb begin
        if ((i_hdr.ip_protocol == PROTO_TCP || i_hdr.ip_protocol == PROTO_UDP)
            && i_hdr.header_words >= IHL_MIN) begin
            port = i_hdr.dest_port;
        end else begin
            port = '0;
        end
        mgmt = port == SVC_SSH || port == SVC_HTTPS || port == SVC_BGP ||
               port == SVC_DHCPS || port == SVC_DHCPC || port == SVC_DNS ||
               port == SVC_SNMP;
    end

    always_comb begin
        if (i_hdr.eth_type != ETYPE_IPV4) begin
            cls = (i_hdr.eth_type == ETYPE_ARP) ? VD_LOCAL : VD_FORWARD;
        end else if (i_hdr.ip_protocol == PROTO_OSPF || mgmt) begin
            cls = VD_LOCAL;
        end else if (i_hdr.from_fabric) begin
            cls = VD_FORWARD;
        end else if (i_hit) begin
            cls = VD_PUNT;
        end else begin
            cls = VD_FORWARD;
        end
    end

    // next nic wraps modulo the clamped nic count, at most four subtracts
    always_comb begin
        nics     = (i_nic_count > NIC_COUNT_W'(MAX_NICS)) ? NIC_COUNT_W'(MAX_NICS)
                                                         : i_nic_count;
        next_nic = {1'b0, i_hdr.nic} + NIC_COUNT_W'(1);
        for (int i = 0; i < 4; i++) begin
            if (next_nic >= nics) next_nic = next_nic - nics;
        end
    end

    always_comb begin
        o_item               = '0;
        o_item.verdict       = cls;
        if (cls == VD_PUNT) begin
            o_item.egress_fabric = 1'b1;
        end else if (cls == VD_LOCAL) begin
            o_item.egress_nic = i_hdr.from_fabric ? 3'd0 : i_hdr.nic;
        end else if (i_hdr.from_fabric) begin
            if (nics == '0) o_item.verdict = VD_DROP;
        end else if (nics > NIC_COUNT_W'(1)) begin
            o_item.egress_nic = next_nic[2:0];
        end else begin
            o_item.egress_fabric = 1'b1;
        end
    end

endmodule

>>> design/ipv4_frame_classifier_top.sv
// ----------------------------------------------------------------------------
// ipv4_frame_classifier_top
// ipv4 frame classifier with a writable prefix table
// ----------------------------------------------------------------------------
// i_in_chan carries either one frame byte (action 0) or one prefix table
// write (action 1). Frame bytes come in wire order; frame_last marks the
// last byte, from_fabric and rx_nic are taken from the first byte.
// o_out_chan gives one verdict word per frame, nothing for table writes.
// i_cfg_chan writes the nic count; it is always ready. The user must write it
// only while no frame is in flight; the block does not enforce this.
// The verdict word is registered: the last byte waits in the input
// register until the result register is free, which then loads.
// Throughput: one item per cycle unless a last byte waits on the result
// register; header capture, the parallel compare of all prefix slots and
// the decision sit between those two registers.
// Reset clears the byte offset, the nic count and both stage valids, and
// loads the three default prefixes.
// When the receiver stalls the result register holds; the input register
// still drains bytes and table writes, and holds only a frame's last byte.
// ----------------------------------------------------------------------------
module ipv4_frame_classifier_top #(
    parameter int PREFIX_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipfc_cfg_if.sink     i_cfg_chan,
    ipfc_in_if.sink      i_in_chan,
    ipfc_out_if.source   o_out_chan
);
    import ipfc_pkg::*;

    logic                   r_s0_valid;
    t_in_item               r_s0_item;
    logic                   r_out_valid;
    t_out_item              r_out_item;
    logic [NIC_COUNT_W-1:0] r_nic_count;

    logic       s0_frame;
    logic       s0_last;
    logic       out_free;
    logic       s0_adv;
    t_hdr       hdr;
    logic       hit;
    t_prefix_wr prefix_wr;
    t_out_item  n_out_item;

    assign s0_frame = r_s0_valid && r_s0_item.action == ACT_FRAME;
    assign s0_last  = s0_frame && r_s0_item.frame_last;
    assign out_free = !r_out_valid || o_out_chan.ready;
    assign s0_adv   = r_s0_valid && (!s0_last || out_free);

    assign i_in_chan.ready  = !r_s0_valid || s0_adv;
    assign i_cfg_chan.ready = 1'b1;

    always_comb begin
        prefix_wr.en    = s0_adv && r_s0_item.action == ACT_WRITE;
        prefix_wr.index = r_s0_item.entry_index;
        prefix_wr.net   = r_s0_item.entry_net;
        prefix_wr.len   = r_s0_item.entry_len;
        prefix_wr.valid = r_s0_item.entry_valid;
    end

    ipfc_hdr_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_en     (s0_adv && s0_frame),
        .i_data_byte   (r_s0_item.data_byte),
        .i_frame_last  (r_s0_item.frame_last),
        .i_from_fabric (r_s0_item.from_fabric),
        .i_rx_nic      (r_s0_item.rx_nic),
        .o_hdr         (hdr)
    );

    ipfc_prefix_match #(
        .PREFIX_ENTRIES (PREFIX_ENTRIES)
    ) u_prefix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (prefix_wr),
        .i_addr  (hdr.dest_address),
        .o_hit   (hit)
    );

    ipfc_verdict u_verdict (
        .i_hdr       (hdr),
        .i_hit       (hit),
        .i_nic_count (r_nic_count),
        .o_item      (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_s0_valid <= i_in_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_s0_item <= i_in_chan.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s0_adv && s0_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv && s0_last) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nic_count <= '0;
        end else if (i_cfg_chan.valid && i_cfg_chan.ready) begin
            r_nic_count <= i_cfg_chan.data;
        end
    end

    assign o_out_chan.valid = r_out_valid;
    assign o_out_chan.data  = r_out_item;

`ifndef NO_ASSERTIONS
    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(s0_adv && s0_last))
        else $error("result appeared without a last frame byte");

    a_no_stall_mid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && !s0_last) |-> s0_adv)
        else $error("non-final item held in input register");

    a_drop_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.verdict == VD_DROP)
        |-> (!r_out_item.egress_fabric && r_out_item.egress_nic == '0))
        else $error("drop verdict with an egress");

    a_punt_fabric : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.verdict == VD_PUNT)
        |-> (r_out_item.egress_fabric && r_out_item.egress_nic == '0))
        else $error("punt verdict not on fabric");
`endif

endmodule
